@@ src/lr_pkg.sv @@
// Shared types and constants for the line rasterizer.
// Depends on nothing; every other file imports it.
package lr_pkg;

  // geometry and datapath widths
  localparam int COORD_BITS = 10;
  localparam int COUNT_BITS = COORD_BITS + 1;
  localparam int ERR_BITS   = COORD_BITS + 2;
  localparam int WIDE_BITS  = ERR_BITS + 1;
  localparam int COLOR_BITS = 16;

  // command queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_BITS   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

  // request codes on the input channel
  localparam logic REQ_START   = 1'b0;
  localparam logic REQ_ADVANCE = 1'b1;

  typedef logic [COORD_BITS-1:0]      coord_t;
  typedef logic [COUNT_BITS-1:0]      count_t;
  typedef logic [COLOR_BITS-1:0]      color_t;
  typedef logic signed [ERR_BITS-1:0] err_t;

  // classified operation
  typedef enum logic [1:0] {
    OP_SPAN,
    OP_LINE,
    OP_ADV
  } op_kind_t;

  // queue entry: span area, or line ends plus stepping setup
  typedef struct packed {
    op_kind_t kind;
    coord_t   x0;
    coord_t   y0;
    coord_t   x1;
    coord_t   y1;
    count_t   count;
    coord_t   dx;
    coord_t   dy;
    logic     x_neg;
    logic     y_neg;
  } lr_op_t;

  // queue status seen by front and back
  typedef struct packed {
    logic full;
    logic empty;
  } lr_qstat_t;

endpackage

@@ src/lr_req_if.sv @@
// Request channel: valid/ready handshake with the line request payload.
// Depends on lr_pkg.
interface lr_req_if;
  import lr_pkg::*;

  logic   valid;
  logic   ready;
  logic   req_type;
  coord_t x_start;
  coord_t y_start;
  coord_t x_end;
  coord_t y_end;

  modport source (output valid, req_type, x_start, y_start, x_end, y_end, input ready);
  modport sink   (input valid, req_type, x_start, y_start, x_end, y_end, output ready);
endinterface

@@ src/lr_cmd_if.sv @@
// Command channel: valid/ready handshake with the area-write command payload.
// Depends on lr_pkg.
interface lr_cmd_if;
  import lr_pkg::*;

  logic   valid;
  logic   ready;
  coord_t area_x0;
  coord_t area_y0;
  coord_t area_x1;
  coord_t area_y1;
  count_t pixel_count;
  color_t pixel_color;
  logic   last;

  modport source (output valid, area_x0, area_y0, area_x1, area_y1, pixel_count,
                  pixel_color, last, input ready);
  modport sink   (input valid, area_x0, area_y0, area_x1, area_y1, pixel_count,
                  pixel_color, last, output ready);
endinterface

@@ src/lr_front.sv @@
// Front end: accepts request beats and classifies them into queue entries.
// Depends on lr_pkg and lr_req_if.
module lr_front (
  lr_req_if.sink            req,
  input  lr_pkg::lr_qstat_t qstat,
  output logic              push,
  output lr_pkg::lr_op_t    op
);
  import lr_pkg::*;

  coord_t xs, ys, xe, ye;
  logic   x_neg, y_neg;
  coord_t x_lo, x_hi, y_lo, y_hi;

  // take a beat whenever the queue has room
  assign req.ready = !qstat.full;
  assign push      = req.valid && req.ready;

  assign xs = req.x_start;
  assign ys = req.y_start;
  assign xe = req.x_end;
  assign ye = req.y_end;

  // end ordering and step direction
  assign x_neg = xs > xe;
  assign y_neg = ys > ye;
  assign x_lo  = x_neg ? xe : xs;
  assign x_hi  = x_neg ? xs : xe;
  assign y_lo  = y_neg ? ye : ys;
  assign y_hi  = y_neg ? ys : ye;

  // classify the request
  always_comb begin
    op       = '0;
    op.kind  = OP_ADV;
    op.count = COUNT_BITS'(1);
    if (req.req_type == REQ_START) begin
      if (ys == ye) begin
        op.kind  = OP_SPAN;
        op.x0    = x_lo;
        op.y0    = ys;
        op.x1    = x_hi;
        op.y1    = ys;
        op.count = {1'b0, x_hi} - {1'b0, x_lo} + COUNT_BITS'(1);
      end else if (xs == xe) begin
        op.kind  = OP_SPAN;
        op.x0    = xs;
        op.y0    = y_lo;
        op.x1    = xs;
        op.y1    = y_hi;
        op.count = {1'b0, y_hi} - {1'b0, y_lo} + COUNT_BITS'(1);
      end else begin
        op.kind  = OP_LINE;
        op.x0    = xs;
        op.y0    = ys;
        op.x1    = xe;
        op.y1    = ye;
        op.dx    = x_hi - x_lo;
        op.dy    = y_hi - y_lo;
        op.x_neg = x_neg;
        op.y_neg = y_neg;
      end
    end
  end

endmodule

@@ src/lr_queue.sv @@
// Short queue of classified operations between front and back.
// Depends on lr_pkg.
module lr_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  lr_pkg::lr_op_t    op_in,
  input  logic              pop,
  output lr_pkg::lr_op_t    op_out,
  output lr_pkg::lr_qstat_t qstat
);
  import lr_pkg::*;

  lr_op_t                mem_r [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_BITS-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_BITS-1:0]  cnt_r, cnt_nxt;

  assign qstat.full  = cnt_r == QCNT_BITS'(QUEUE_DEPTH);
  assign qstat.empty = cnt_r == '0;
  assign op_out      = mem_r[rd_ptr_r];

  // pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= op_in;
    end
  end

endmodule

@@ src/lr_back.sv @@
// Back end: Bresenham stepping state and the registered command output.
// Depends on lr_pkg and lr_cmd_if.
module lr_back (
  input  logic              clk,
  input  logic              rst_n,
  input  lr_pkg::lr_op_t    op,
  input  lr_pkg::lr_qstat_t qstat,
  output logic              pop,
  input  lr_pkg::color_t    color,
  lr_cmd_if.source          cmd
);
  import lr_pkg::*;

  // stepping state
  logic   busy_r, busy_nxt;
  coord_t cur_x_r, cur_x_nxt, cur_y_r, cur_y_nxt;
  coord_t goal_x_r, goal_x_nxt, goal_y_r, goal_y_nxt;
  coord_t dx_r, dx_nxt, dy_r, dy_nxt;
  logic   x_neg_r, x_neg_nxt, y_neg_r, y_neg_nxt;
  err_t   err_r, err_nxt;

  // output register
  logic   out_valid_r, out_valid_nxt;
  coord_t x0_r, x0_nxt, y0_r, y0_nxt, x1_r, x1_nxt, y1_r, y1_nxt;
  count_t count_r, count_nxt;
  color_t color_r, color_nxt;
  logic   last_r, last_nxt;

  logic   out_free;
  logic   emit;

  // one Bresenham step from the current state
  logic signed [WIDE_BITS-1:0] e2, dx_w, dy_w, err_w, err_acc;
  logic   step_x, step_y;
  coord_t step_cx, step_cy;
  logic   step_done;
  err_t   step_err, init_err;

  assign out_free = !out_valid_r || cmd.ready;
  assign pop      = !qstat.empty && out_free;

  assign e2    = {err_r, 1'b0};
  assign dx_w  = {{(WIDE_BITS - COORD_BITS){1'b0}}, dx_r};
  assign dy_w  = {{(WIDE_BITS - COORD_BITS){1'b0}}, dy_r};
  assign err_w = {err_r[ERR_BITS-1], err_r};

  assign step_x  = e2 > -dy_w;
  assign step_y  = e2 < dx_w;
  assign err_acc = err_w - (step_x ? dy_w : '0) + (step_y ? dx_w : '0);
  assign step_err = $signed(err_acc[ERR_BITS-1:0]);

  assign step_cx = step_x ? (x_neg_r ? cur_x_r - 1'b1 : cur_x_r + 1'b1) : cur_x_r;
  assign step_cy = step_y ? (y_neg_r ? cur_y_r - 1'b1 : cur_y_r + 1'b1) : cur_y_r;
  assign step_done = (step_cx == goal_x_r) && (step_cy == goal_y_r);

  // initial error dx - dy for a new line
  assign init_err = $signed({{(ERR_BITS - COORD_BITS){1'b0}}, op.dx})
                  - $signed({{(ERR_BITS - COORD_BITS){1'b0}}, op.dy});

  // operation execution
  always_comb begin
    busy_nxt   = busy_r;
    cur_x_nxt  = cur_x_r;
    cur_y_nxt  = cur_y_r;
    goal_x_nxt = goal_x_r;
    goal_y_nxt = goal_y_r;
    dx_nxt     = dx_r;
    dy_nxt     = dy_r;
    x_neg_nxt  = x_neg_r;
    y_neg_nxt  = y_neg_r;
    err_nxt    = err_r;
    emit       = 1'b0;
    x0_nxt     = x0_r;
    y0_nxt     = y0_r;
    x1_nxt     = x1_r;
    y1_nxt     = y1_r;
    count_nxt  = count_r;
    last_nxt   = last_r;
    if (pop) begin
      unique case (op.kind)
        OP_SPAN: begin
          busy_nxt  = 1'b0;
          emit      = 1'b1;
          x0_nxt    = op.x0;
          y0_nxt    = op.y0;
          x1_nxt    = op.x1;
          y1_nxt    = op.y1;
          count_nxt = op.count;
          last_nxt  = 1'b1;
        end
        OP_LINE: begin
          busy_nxt   = 1'b1;
          cur_x_nxt  = op.x0;
          cur_y_nxt  = op.y0;
          goal_x_nxt = op.x1;
          goal_y_nxt = op.y1;
          dx_nxt     = op.dx;
          dy_nxt     = op.dy;
          x_neg_nxt  = op.x_neg;
          y_neg_nxt  = op.y_neg;
          err_nxt    = init_err;
          emit       = 1'b1;
          x0_nxt     = op.x0;
          y0_nxt     = op.y0;
          x1_nxt     = op.x0;
          y1_nxt     = op.y0;
          count_nxt  = COUNT_BITS'(1);
          last_nxt   = 1'b0;
        end
        OP_ADV: begin
          // advance while idle is dropped
          if (busy_r) begin
            cur_x_nxt = step_cx;
            cur_y_nxt = step_cy;
            err_nxt   = step_err;
            busy_nxt  = !step_done;
            emit      = 1'b1;
            x0_nxt    = step_cx;
            y0_nxt    = step_cy;
            x1_nxt    = step_cx;
            y1_nxt    = step_cy;
            count_nxt = COUNT_BITS'(1);
            last_nxt  = step_done;
          end
        end
        default: begin
          emit = 1'b0;
        end
      endcase
    end
  end

  // output valid and color capture
  always_comb begin
    color_nxt = emit ? color : color_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (cmd.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_x_r  <= cur_x_nxt;
    cur_y_r  <= cur_y_nxt;
    goal_x_r <= goal_x_nxt;
    goal_y_r <= goal_y_nxt;
    dx_r     <= dx_nxt;
    dy_r     <= dy_nxt;
    x_neg_r  <= x_neg_nxt;
    y_neg_r  <= y_neg_nxt;
    err_r    <= err_nxt;
    x0_r     <= x0_nxt;
    y0_r     <= y0_nxt;
    x1_r     <= x1_nxt;
    y1_r     <= y1_nxt;
    count_r  <= count_nxt;
    color_r  <= color_nxt;
    last_r   <= last_nxt;
  end

  // command outputs
  assign cmd.valid       = out_valid_r;
  assign cmd.area_x0     = x0_r;
  assign cmd.area_y0     = y0_r;
  assign cmd.area_x1     = x1_r;
  assign cmd.area_y1     = y1_r;
  assign cmd.pixel_count = count_r;
  assign cmd.pixel_color = color_r;
  assign cmd.last        = last_r;

  // a line in progress never sits on its endpoint
  a_busy_not_at_goal: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (cur_x_r != goal_x_r) || (cur_y_r != goal_y_r))
    else $error("line busy while already at endpoint");

  // only the closing command of a line covers more than one pixel
  a_multi_pixel_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !last_r |-> count_r == COUNT_BITS'(1))
    else $error("multi-pixel command not flagged last");

  // write areas are always ordered
  a_area_ordered: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (x0_r <= x1_r) && (y0_r <= y1_r))
    else $error("write area ends out of order");

  // a pending command is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !cmd.ready |-> !emit)
    else $error("command register overwritten while stalled");

endmodule

@@ src/line_rasterizer.sv @@
// Line rasterizer top level: draw color register, front end, queue, back end.
// Depends on lr_pkg, lr_req_if, lr_cmd_if, lr_front, lr_queue and lr_back.
//
//   port      dir   handshake        beat carries
//   in_ch     in    valid / ready    req_type, x_start, y_start, x_end, y_end
//   out_ch    out   valid / ready    area_x0..area_y1, pixel_count, pixel_color, last
//   cfg_*     in    cfg_we           cfg_wdata -> draw color
//
// One request beat per cycle sustained while out_ch.ready stays high; the back end's
// stepping unit emits at most one command per cycle. A request beat reaches command
// valid through the queue write and then the back end's output register.
// Synchronous active-low reset empties the queue, clears the line-busy flag, the
// output valid and the draw color.
// in_ch.ready drops only when the two-entry queue is full; the back end holds
// while a command waits in its output register and out_ch.ready is low.
module line_rasterizer (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           cfg_we,
  input  lr_pkg::color_t cfg_wdata,
  lr_req_if.sink         in_ch,
  lr_cmd_if.source       out_ch
);
  import lr_pkg::*;

  color_t    draw_color_r;
  lr_op_t    front_op;
  lr_op_t    queue_op;
  lr_qstat_t qstat;
  logic      push;
  logic      pop;

  // draw color register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      draw_color_r <= '0;
    end else if (cfg_we) begin
      draw_color_r <= cfg_wdata;
    end
  end

  lr_front u_front (
    .req   (in_ch),
    .qstat (qstat),
    .push  (push),
    .op    (front_op)
  );

  lr_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .op_in  (front_op),
    .pop    (pop),
    .op_out (queue_op),
    .qstat  (qstat)
  );

  lr_back u_back (
    .clk   (clk),
    .rst_n (rst_n),
    .op    (queue_op),
    .qstat (qstat),
    .pop   (pop),
    .color (draw_color_r),
    .cmd   (out_ch)
  );

endmodule

@@ bench/line_rasterizer_tb.sv @@
// Self-checking bench for line_rasterizer: spans, stepped lines, restarts, draw color.
// Depends on lr_pkg, lr_req_if, lr_cmd_if and the line_rasterizer RTL.
// A local Bresenham predictor queues the commands that each accepted request beat implies.
module line_rasterizer_tb;
  import lr_pkg::*;

  localparam int RANDOM_ITEMS  = 1000;
  localparam int SETTLE_CYCLES = 8;
  localparam int STALL_LIMIT   = 500;
  localparam int MAX_COORD     = (1 << COORD_BITS) - 1;
  localparam int MAX_REPORTS   = 40;

  typedef struct {
    logic   req_type;
    coord_t xs;
    coord_t ys;
    coord_t xe;
    coord_t ye;
  } line_req_t;

  typedef struct {
    coord_t x0;
    coord_t y0;
    coord_t x1;
    coord_t y1;
    count_t count;
    color_t color;
    logic   last;
  } area_cmd_t;

  logic   clk;
  logic   rst_n;
  logic   cfg_we;
  color_t cfg_wdata;

  lr_req_if req_bus ();
  lr_cmd_if cmd_bus ();

  line_rasterizer DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_ch     (req_bus),
    .out_ch    (cmd_bus)
  );

  // predictor copy of the register and the stepping state
  color_t draw_color_q;
  logic   line_busy;
  coord_t pen_x;
  coord_t pen_y;
  coord_t goal_x;
  coord_t goal_y;
  coord_t run_x;
  coord_t run_y;
  logic   x_back;
  logic   y_back;
  err_t   step_err;

  area_cmd_t expected_cmds[$];

  // bookkeeping
  int  error_count      = 0;
  int  req_beats        = 0;
  int  ignored_advances = 0;
  int  result_items     = 0;
  int  cmds_checked     = 0;
  int  colors_written   = 0;
  int  pending_gap      = 0;
  bit  valid_up         = 0;
  bit  no_gaps          = 0;

  // clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic int draw_wait();
    if (no_gaps) return 0;
    return int'($urandom_range(0, 6));
  endfunction

  function automatic coord_t near_coord(coord_t base);
    int v;
    v = int'($urandom_range(0, 24)) - 12 + int'(base);
    if (v < 0) v = 0;
    if (v > MAX_COORD) v = MAX_COORD;
    return coord_t'(v);
  endfunction

  // bresenham predictor: pushes the command a request beat causes, if any
  task automatic rasterize_request(input line_req_t r);
    area_cmd_t c;
    coord_t    lo;
    coord_t    hi;
    int        e1;
    int        e2;
    int        dxi;
    int        dyi;
    c.color = draw_color_q;
    if (r.req_type == REQ_START) begin
      line_busy = 1'b0;
      if (r.ys == r.ye) begin
        lo = (r.xs < r.xe) ? r.xs : r.xe;
        hi = (r.xs < r.xe) ? r.xe : r.xs;
        c.x0 = lo;
        c.y0 = r.ys;
        c.x1 = hi;
        c.y1 = r.ys;
        c.count = count_t'(int'(hi) - int'(lo) + 1);
        c.last = 1'b1;
      end else if (r.xs == r.xe) begin
        lo = (r.ys < r.ye) ? r.ys : r.ye;
        hi = (r.ys < r.ye) ? r.ye : r.ys;
        c.x0 = r.xs;
        c.y0 = lo;
        c.x1 = r.xs;
        c.y1 = hi;
        c.count = count_t'(int'(hi) - int'(lo) + 1);
        c.last = 1'b1;
      end else begin
        x_back   = r.xs > r.xe;
        run_x    = x_back ? r.xs - r.xe : r.xe - r.xs;
        y_back   = r.ys > r.ye;
        run_y    = y_back ? r.ys - r.ye : r.ye - r.ys;
        step_err = err_t'(int'(run_x) - int'(run_y));
        pen_x    = r.xs;
        pen_y    = r.ys;
        goal_x   = r.xe;
        goal_y   = r.ye;
        line_busy = 1'b1;
        c.x0 = r.xs;
        c.y0 = r.ys;
        c.x1 = r.xs;
        c.y1 = r.ys;
        c.count = count_t'(1);
        c.last = 1'b0;
      end
    end else if (line_busy) begin
      dxi = int'(run_x);
      dyi = int'(run_y);
      e1  = int'(step_err);
      e2  = 2 * e1;
      if (e2 > -dyi) begin
        e1 -= dyi;
        pen_x = x_back ? pen_x - 1'b1 : pen_x + 1'b1;
      end
      if (e2 < dxi) begin
        e1 += dxi;
        pen_y = y_back ? pen_y - 1'b1 : pen_y + 1'b1;
      end
      step_err = err_t'(e1);
      c.x0 = pen_x;
      c.y0 = pen_y;
      c.x1 = pen_x;
      c.y1 = pen_y;
      c.count = count_t'(1);
      c.last = (pen_x == goal_x) && (pen_y == goal_y);
      if (c.last) line_busy = 1'b0;
    end else begin
      // advance with no line in progress
      ignored_advances++;
      return;
    end
    expected_cmds.push_back(c);
    result_items++;
  endtask

  // one request beat; valid stays up when the next beat follows at once
  task automatic send_request(input logic kind, input coord_t xs, input coord_t ys,
                              input coord_t xe, input coord_t ye);
    line_req_t r;
    r.req_type = kind;
    r.xs = xs;
    r.ys = ys;
    r.xe = xe;
    r.ye = ye;
    if (pending_gap != 0) repeat (pending_gap) @(posedge clk);
    req_bus.valid    <= 1'b1;
    req_bus.req_type <= kind;
    req_bus.x_start  <= xs;
    req_bus.y_start  <= ys;
    req_bus.x_end    <= xe;
    req_bus.y_end    <= ye;
    valid_up = 1'b1;
    @(posedge clk);
    while (!req_bus.ready) @(posedge clk);
    req_beats++;
    rasterize_request(r);
    pending_gap = draw_wait();
    if (pending_gap != 0) begin
      req_bus.valid <= 1'b0;
      valid_up = 1'b0;
    end
  endtask

  // advance beats carry random, ignored coordinates
  task automatic send_advance();
    send_request(REQ_ADVANCE, coord_t'($urandom), coord_t'($urandom),
                 coord_t'($urandom), coord_t'($urandom));
  endtask

  // start a line and step it to its end, or stop after stop_at advances
  task automatic trace_line(input coord_t xs, input coord_t ys, input coord_t xe,
                            input coord_t ye, input int stop_at);
    int steps;
    steps = 0;
    send_request(REQ_START, xs, ys, xe, ye);
    while (line_busy && steps != stop_at) begin
      send_advance();
      steps++;
    end
  endtask

  // drop valid, drain all expected commands, let the pipeline settle
  task automatic wait_idle();
    if (valid_up) begin
      req_bus.valid <= 1'b0;
      valid_up = 1'b0;
    end
    while (expected_cmds.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_color(input color_t c);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_wdata <= c;
    @(posedge clk);
    cfg_we <= 1'b0;
    draw_color_q = c;
    colors_written++;
  endtask

  task automatic compare_field(input string name, input int unsigned want,
                               input int unsigned got);
    if (want != got) begin
      error_count++;
      if (error_count <= MAX_REPORTS)
        $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
    end
  endtask

  task automatic check_command(input area_cmd_t got);
    area_cmd_t want;
    if (expected_cmds.size() == 0) begin
      error_count++;
      if (error_count <= MAX_REPORTS)
        $display("%0t: unexpected command, expected none actual (%0d,%0d)-(%0d,%0d) n=%0d",
                 $time, got.x0, got.y0, got.x1, got.y1, got.count);
    end else begin
      want = expected_cmds.pop_front();
      compare_field("area_x0", want.x0, got.x0);
      compare_field("area_y0", want.y0, got.y0);
      compare_field("area_x1", want.x1, got.x1);
      compare_field("area_y1", want.y1, got.y1);
      compare_field("pixel_count", want.count, got.count);
      compare_field("pixel_color", want.color, got.color);
      compare_field("last", want.last, got.last);
      cmds_checked++;
    end
  endtask

  // command sink with random back-pressure
  initial begin : result_sink
    area_cmd_t got;
    int        stall;
    cmd_bus.ready = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      stall = draw_wait();
      if (stall != 0) begin
        cmd_bus.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      cmd_bus.ready <= 1'b1;
      @(posedge clk);
      while (!cmd_bus.valid) @(posedge clk);
      got.x0    = cmd_bus.area_x0;
      got.y0    = cmd_bus.area_y0;
      got.x1    = cmd_bus.area_x1;
      got.y1    = cmd_bus.area_y1;
      got.count = cmd_bus.pixel_count;
      got.color = cmd_bus.pixel_color;
      got.last  = cmd_bus.last;
      check_command(got);
    end
  end

  // watchdog on cycles without any beat
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((req_bus.valid && req_bus.ready) || (cmd_bus.valid && cmd_bus.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("%0t: no beat for %0d cycles", $time, STALL_LIMIT);
    $display("FAIL line_rasterizer");
    $finish;
  end

  // reset color, idle advance, single points
  task automatic test_after_reset();
    send_advance();
    send_request(REQ_START, coord_t'(0), coord_t'(0), coord_t'(0), coord_t'(0));
    send_request(REQ_START, coord_t'(MAX_COORD), coord_t'(MAX_COORD),
                 coord_t'(MAX_COORD), coord_t'(MAX_COORD));
  endtask

  // full-width and full-height spans in both orders
  task automatic test_spans();
    set_color(16'hFFFF);
    send_request(REQ_START, coord_t'(MAX_COORD), coord_t'(7), coord_t'(0), coord_t'(7));
    send_request(REQ_START, coord_t'(0), coord_t'(MAX_COORD),
                 coord_t'(MAX_COORD), coord_t'(MAX_COORD));
    send_request(REQ_START, coord_t'(3), coord_t'(MAX_COORD), coord_t'(3), coord_t'(0));
    send_request(REQ_START, coord_t'(MAX_COORD), coord_t'(0),
                 coord_t'(MAX_COORD), coord_t'(MAX_COORD));
  endtask

  // stepped lines to the end, then an advance past the end
  task automatic test_angled_lines();
    set_color(16'h0000);
    trace_line(coord_t'(10), coord_t'(10), coord_t'(13), coord_t'(12), -1);
    send_advance();
    trace_line(coord_t'(MAX_COORD), coord_t'(0), coord_t'(MAX_COORD - 3), coord_t'(5), -1);
  endtask

  // new start while a line is in progress
  task automatic test_restart();
    set_color(16'hA5C3);
    trace_line(coord_t'(0), coord_t'(MAX_COORD), coord_t'(20), coord_t'(MAX_COORD - 23), 2);
    trace_line(coord_t'(MAX_COORD), coord_t'(MAX_COORD), coord_t'(MAX_COORD - 2),
               coord_t'(MAX_COORD - 2), -1);
    send_advance();
  endtask

  // mostly complete short lines with random content, some noise and aborts
  task automatic random_line();
    coord_t xs;
    coord_t ys;
    coord_t xe;
    coord_t ye;
    int     pick;
    int     stop_at;
    xs   = coord_t'($urandom);
    ys   = coord_t'($urandom);
    pick = $urandom_range(0, 59);
    if (pick == 0) begin
      xe = coord_t'($urandom);
      ye = coord_t'($urandom);
    end else if (pick < 8) begin
      xe = coord_t'($urandom);
      ye = ys;
    end else if (pick < 14) begin
      xe = xs;
      ye = coord_t'($urandom);
    end else begin
      xe = near_coord(xs);
      ye = near_coord(ys);
    end
    stop_at = ($urandom_range(0, 7) == 0) ? int'($urandom_range(0, 6)) : -1;
    trace_line(xs, ys, xe, ye, stop_at);
    if ($urandom_range(0, 5) == 0) send_advance();
  endtask

  task automatic test_random_lines();
    int target;
    for (int chunk = 0; chunk < 4; chunk++) begin
      set_color(color_t'($urandom));
      no_gaps = (chunk == 2);
      target = result_items + RANDOM_ITEMS / 4;
      while (result_items < target) begin
        if ($urandom_range(0, 4) == 0) begin
          if ($urandom_range(0, 1) == 0)
            send_request(REQ_START, coord_t'($urandom), coord_t'($urandom),
                         coord_t'($urandom), coord_t'($urandom));
          else
            send_advance();
        end else begin
          random_line();
        end
      end
    end
    no_gaps = 0;
  endtask

  // main sequence
  initial begin
    rst_n            = 1'b0;
    cfg_we           = 1'b0;
    cfg_wdata        = '0;
    req_bus.valid    = 1'b0;
    req_bus.req_type = REQ_START;
    req_bus.x_start  = '0;
    req_bus.y_start  = '0;
    req_bus.x_end    = '0;
    req_bus.y_end    = '0;
    draw_color_q     = '0;
    line_busy        = 1'b0;
    pen_x            = '0;
    pen_y            = '0;
    goal_x           = '0;
    goal_y           = '0;
    run_x            = '0;
    run_y            = '0;
    x_back           = 1'b0;
    y_back           = 1'b0;
    step_err         = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    test_after_reset();
    test_spans();
    test_angled_lines();
    test_restart();
    test_random_lines();
    wait_idle();

    $display("covered %0d request beats (%0d idle advances), %0d commands checked",
             req_beats, ignored_advances, cmds_checked);
    $display("spans, stepped lines, restarts and %0d draw color writes", colors_written);
    if (error_count == 0 && expected_cmds.size() == 0) begin
      $display("PASS line_rasterizer");
    end else begin
      $display("%0d mismatches, %0d commands still expected", error_count,
               expected_cmds.size());
      $display("FAIL line_rasterizer");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
src/lr_pkg.sv
src/lr_req_if.sv
src/lr_cmd_if.sv
src/lr_front.sv
src/lr_queue.sv
src/lr_back.sv
src/line_rasterizer.sv
bench/line_rasterizer_tb.sv
